>>> hdl/calendar_date_days_back_unit_macros.svh
// Assertion macros for the calendar date days-back unit.
// Assumes clk_i and rst_ni are in scope at the place of use.
`ifndef CALENDAR_DATE_DAYS_BACK_UNIT_MACROS_SVH
`define CALENDAR_DATE_DAYS_BACK_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define CDDB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("calendar date unit: same-cycle check failed");
`define CDDB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("calendar date unit: next-cycle check failed");
`else
`define CDDB_ASSERT_IMP(lbl, ante, cons)
`define CDDB_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> hdl/cddb_pkg.sv
// Package for the calendar date days-back unit: microcode word, step, condition
// and operation codes, the control program and the month start table.
// No dependencies.
package cddb_pkg;

  localparam int unsigned PcW   = 3;
  localparam int unsigned CondW = 3;
  localparam int unsigned OpW   = 3;

  localparam logic [PcW-1:0] STEP_IDLE  = 3'd0;
  localparam logic [PcW-1:0] STEP_DOY   = 3'd1;
  localparam logic [PcW-1:0] STEP_YEAR  = 3'd2;
  localparam logic [PcW-1:0] STEP_SUB   = 3'd3;
  localparam logic [PcW-1:0] STEP_MONTH = 3'd4;
  localparam logic [PcW-1:0] STEP_MUL   = 3'd5;
  localparam logic [PcW-1:0] STEP_EMIT  = 3'd6;

  localparam logic [CondW-1:0] C_NEVER       = 3'd0;
  localparam logic [CondW-1:0] C_NO_INPUT    = 3'd1;
  localparam logic [CondW-1:0] C_BACK_LT_DOY = 3'd2;
  localparam logic [CondW-1:0] C_MONTH_FOUND = 3'd3;
  localparam logic [CondW-1:0] C_OUT_BUSY    = 3'd4;

  localparam logic [OpW-1:0] OP_NOP       = 3'd0;
  localparam logic [OpW-1:0] OP_LOAD      = 3'd1;
  localparam logic [OpW-1:0] OP_DOY       = 3'd2;
  localparam logic [OpW-1:0] OP_YEAR_BACK = 3'd3;
  localparam logic [OpW-1:0] OP_SUB_BACK  = 3'd4;
  localparam logic [OpW-1:0] OP_MONTH_DEC = 3'd5;
  localparam logic [OpW-1:0] OP_DAY_MUL   = 3'd6;
  localparam logic [OpW-1:0] OP_EMIT      = 3'd7;

  localparam logic [3:0]  MonthFirst = 4'd1;
  localparam logic [3:0]  MonthLast  = 4'd12;
  localparam logic [24:0] YearScale  = 25'd10000;
  localparam logic [24:0] MonthScale = 25'd100;
  localparam logic [15:0] DaysCommon = 16'd365;
  localparam logic [15:0] DaysLeap   = 16'd366;

  // When the condition holds the step jumps to tgt, otherwise it runs op and goes to nxt.
  typedef struct packed {
    logic [CondW-1:0] cond;
    logic [PcW-1:0]   tgt;
    logic [OpW-1:0]   op;
    logic [PcW-1:0]   nxt;
  } cddb_uword_t;

  function automatic cddb_uword_t ucode(input logic [PcW-1:0] pc);
    cddb_uword_t w;
    unique case (pc)
      STEP_IDLE:  w = '{C_NO_INPUT,    STEP_IDLE,  OP_LOAD,      STEP_DOY};
      STEP_DOY:   w = '{C_NEVER,       STEP_IDLE,  OP_DOY,       STEP_YEAR};
      STEP_YEAR:  w = '{C_BACK_LT_DOY, STEP_SUB,   OP_YEAR_BACK, STEP_YEAR};
      STEP_SUB:   w = '{C_NEVER,       STEP_IDLE,  OP_SUB_BACK,  STEP_MONTH};
      STEP_MONTH: w = '{C_MONTH_FOUND, STEP_MUL,   OP_MONTH_DEC, STEP_MONTH};
      STEP_MUL:   w = '{C_NEVER,       STEP_IDLE,  OP_DAY_MUL,   STEP_EMIT};
      STEP_EMIT:  w = '{C_OUT_BUSY,    STEP_EMIT,  OP_EMIT,      STEP_IDLE};
      default:    w = '{C_NEVER,       STEP_IDLE,  OP_NOP,       STEP_IDLE};
    endcase
    return w;
  endfunction

  // Days before the first of month m, one more from March on in a leap year.
  function automatic logic [8:0] start_of(input logic [3:0] m, input logic leap);
    logic [8:0] s;
    unique case (m)
      4'd2:    s = 9'd31;
      4'd3:    s = 9'd59;
      4'd4:    s = 9'd90;
      4'd5:    s = 9'd120;
      4'd6:    s = 9'd151;
      4'd7:    s = 9'd181;
      4'd8:    s = 9'd212;
      4'd9:    s = 9'd243;
      4'd10:   s = 9'd273;
      4'd11:   s = 9'd304;
      4'd12:   s = 9'd334;
      default: s = 9'd0;
    endcase
    if (m >= 4'd3 && leap) begin
      s = s + 9'd1;
    end
    return s;
  endfunction

endpackage

>>> hdl/calendar_date_days_back_unit.sv
// The microcode loads a request, forms its day of year, steps back whole years,
// subtracts the rest, searches the months and packs the date; one request at a time.
// A finished result waits in the output register while the next request is taken.
// Reset returns the sequencer to its idle step and clears the output valid flag.
`include "calendar_date_days_back_unit_macros.svh"
module calendar_date_days_back_unit
  import cddb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // start_year[11:0], start_month[15:12], start_day[20:16], days_back[35:21]
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // result_year[11:0], result_month[15:12], result_day[20:16], packed_date[45:21]
  output logic [47:0] m_axis_tdata
);

  logic [PcW-1:0] pc_q, pc_d;
  cddb_uword_t    uw;
  logic           take;

  logic [12:0] year_q, year_d;
  logic [15:0] doy_q, doy_d;
  logic [14:0] back_q, back_d;
  logic [3:0]  m_q, m_d;
  logic [4:0]  day_q, day_d;
  logic [24:0] prod_q, prod_d;

  logic        out_valid_q, out_valid_d;
  logic [45:0] out_data_q, out_data_d;

  logic [3:0]  in_month;
  logic [12:0] year_m1;
  logic [8:0]  m_start;
  logic [24:0] packed_sum;

  assign uw       = ucode(pc_q);
  assign year_m1  = year_q - 13'd1;
  assign m_start  = start_of(m_q, year_q[1:0] == 2'b00);

  always_comb begin
    if (s_axis_tdata[15:12] < MonthFirst) begin
      in_month = MonthFirst;
    end else if (s_axis_tdata[15:12] > MonthLast) begin
      in_month = MonthLast;
    end else begin
      in_month = s_axis_tdata[15:12];
    end
  end

  always_comb begin
    unique case (uw.cond)
      C_NEVER:       take = 1'b0;
      C_NO_INPUT:    take = !s_axis_tvalid;
      C_BACK_LT_DOY: take = {1'b0, back_q} < doy_q;
      C_MONTH_FOUND: take = (m_q == MonthFirst) || ({7'd0, m_start} < doy_q);
      C_OUT_BUSY:    take = out_valid_q && !m_axis_tready;
      default:       take = 1'b0;
    endcase
  end

  assign packed_sum = prod_q + 25'(m_q) * MonthScale + 25'(day_q);

  always_comb begin
    pc_d        = take ? uw.tgt : uw.nxt;
    year_d      = year_q;
    doy_d       = doy_q;
    back_d      = back_q;
    m_d         = m_q;
    day_d       = day_q;
    prod_d      = prod_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    if (!take) begin
      unique case (uw.op)
        OP_NOP: begin
        end
        OP_LOAD: begin
          year_d = {1'b0, s_axis_tdata[11:0]};
          m_d    = in_month;
          day_d  = s_axis_tdata[20:16];
          back_d = s_axis_tdata[35:21];
        end
        OP_DOY: begin
          doy_d = {7'd0, m_start} + {11'd0, day_q};
        end
        OP_YEAR_BACK: begin
          year_d = year_m1;
          doy_d  = doy_q + ((year_m1[1:0] == 2'b00) ? DaysLeap : DaysCommon);
        end
        OP_SUB_BACK: begin
          doy_d = doy_q - {1'b0, back_q};
          m_d   = MonthLast;
        end
        OP_MONTH_DEC: begin
          m_d = m_q - 4'd1;
        end
        OP_DAY_MUL: begin
          day_d  = 5'(doy_q[8:0] - m_start);
          prod_d = 25'({{12{year_q[12]}}, year_q} * YearScale);
        end
        OP_EMIT: begin
          out_data_d  = {packed_sum, day_q, m_q, year_q[11:0]};
          out_valid_d = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= STEP_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    year_q     <= year_d;
    doy_q      <= doy_d;
    back_q     <= back_d;
    m_q        <= m_d;
    day_q      <= day_d;
    prod_q     <= prod_d;
    out_data_q <= out_data_d;
  end

  assign s_axis_tready = (uw.op == OP_LOAD);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_data_q};

  `CDDB_ASSERT_NXT(a_accept_starts, s_axis_tvalid && s_axis_tready, pc_q == STEP_DOY)
  `CDDB_ASSERT_IMP(a_month_range, pc_q == STEP_MONTH, m_q >= MonthFirst && m_q <= MonthLast)
  `CDDB_ASSERT_IMP(a_doy_range, pc_q == STEP_MONTH, doy_q != 16'd0 && doy_q <= DaysLeap)

endmodule
